FILE: rtl/nsm_pkg.sv
package nsm_pkg;

    // signature table, longest entry sets the stored width
    localparam int TABLE_RULES = 23;
    localparam int TBL_CHARS   = 18;

    // queued request kinds
    localparam logic [1:0] OP_SKIP  = 2'd0;
    localparam logic [1:0] OP_SCAN  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CAT_SQLI = 2'd0;
    localparam logic [1:0] CAT_XSS  = 2'd1;
    localparam logic [1:0] CAT_PATH = 2'd2;
    localparam logic [1:0] CAT_CMD  = 2'd3;

    typedef struct packed {
        logic [7:0] ch;     // case-folded byte
        logic [1:0] op;
        logic       last;
    } req_t;

    // strings are right-justified: character k sits at byte (len-1-k)
    localparam logic [TBL_CHARS*8-1:0] SIG_TEXT [TABLE_RULES] = '{
        "union select", "union all select", "or 1=1", "' or '", "select * from",
        {"information", "_schema"}, "<script>", "javascript:", "onerror=", "onload=",
        "alert(", "<svg/onload", "../", "..\\", "/etc/passwd",
        "/windows/win.ini", "..\\..", "; sh ", "; bash ", "| sh ",
        "| bash ", "&& id", "&& whoami"
    };

    localparam logic [4:0] SIG_LEN [TABLE_RULES] = '{
        5'd12, 5'd16, 5'd6, 5'd6, 5'd13, 5'd18, 5'd8, 5'd11, 5'd8, 5'd7,
        5'd6, 5'd11, 5'd3, 5'd3, 5'd11, 5'd16, 5'd5, 5'd5, 5'd7, 5'd5,
        5'd7, 5'd5, 5'd9
    };

    localparam logic [1:0] SIG_CAT [TABLE_RULES] = '{
        CAT_SQLI, CAT_SQLI, CAT_SQLI, CAT_SQLI, CAT_SQLI, CAT_SQLI,
        CAT_XSS, CAT_XSS, CAT_XSS, CAT_XSS, CAT_XSS, CAT_XSS,
        CAT_PATH, CAT_PATH, CAT_PATH, CAT_PATH, CAT_PATH,
        CAT_CMD, CAT_CMD, CAT_CMD, CAT_CMD, CAT_CMD, CAT_CMD
    };

endpackage

FILE: rtl/nsm_front.sv
module nsm_front #(
    parameter int MAX_TEXT_LEN = 4095
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_data,
    input  logic          s_last,
    output logic          push_valid,
    input  logic          push_ready,
    output nsm_pkg::req_t push_req
);

    localparam int CNT_W = $clog2(MAX_TEXT_LEN + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ended_reg, ended_next;
    logic             take;
    logic             live;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign take       = s_valid && push_ready;
    assign live       = !ended_reg && (count_reg < CNT_W'(MAX_TEXT_LEN));

    always_comb
    begin
        push_req.last = s_last;
        push_req.ch   = (s_data inside {[8'h41:8'h5A]}) ? (s_data + 8'h20) : s_data;
        if (!live)
        begin
            push_req.op = nsm_pkg::OP_SKIP;
        end
        else if (s_data == 8'h00)
        begin
            push_req.op = nsm_pkg::OP_CLEAR;
        end
        else
        begin
            push_req.op = nsm_pkg::OP_SCAN;
        end

        count_next = count_reg;
        ended_next = ended_reg;
        if (take)
        begin
            if (s_last)
            begin
                count_next = '0;
                ended_next = 1'b0;
            end
            else if (push_req.op == nsm_pkg::OP_CLEAR)
            begin
                ended_next = 1'b1;
            end
            else if (push_req.op == nsm_pkg::OP_SCAN)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ended_reg <= ended_next;
        end
    end

endmodule

FILE: rtl/nsm_fifo.sv
module nsm_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  nsm_pkg::req_t push_req,
    output logic          pop_valid,
    input  logic          pop,
    output nsm_pkg::req_t pop_req
);

    localparam int CNT_W = $clog2(nsm_pkg::QUEUE_DEPTH + 1);

    nsm_pkg::req_t                mem_reg [nsm_pkg::QUEUE_DEPTH];
    logic [nsm_pkg::QPTR_W-1:0]   wr_reg, wr_next;
    logic [nsm_pkg::QPTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(nsm_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_req    = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + nsm_pkg::QPTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + nsm_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_req;
        end
    end

    // occupancy must track the pointer distance
    a_cnt_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != CNT_W'(nsm_pkg::QUEUE_DEPTH)) && (cnt_reg != '0)
            |-> (wr_reg != rd_reg))
        else $error("queue count disagrees with pointers");

endmodule

FILE: rtl/nsm_back.sv
module nsm_back #(
    parameter int NUM_RULES       = 23,
    parameter int MAX_PATTERN_LEN = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_pop,
    input  nsm_pkg::req_t q_req,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_data
);

    localparam int ACTIVE = (NUM_RULES < nsm_pkg::TABLE_RULES) ? NUM_RULES
                                                                : nsm_pkg::TABLE_RULES;

    logic [MAX_PATTERN_LEN-1:0] part_reg  [ACTIVE];
    logic [MAX_PATTERN_LEN-1:0] part_next [ACTIVE];
    logic [MAX_PATTERN_LEN-1:0] step_vec  [ACTIVE];
    logic [ACTIVE-1:0]          hit;
    logic [ACTIVE-1:0]          match_reg, match_next, match_acc;
    logic                       oval_reg, oval_next;
    logic [7:0]                 odat_reg, odat_next;
    logic                       blk;
    logic [4:0]                 idx;
    logic [1:0]                 cat;

    // shift-and step for every rule in parallel
    for (genvar r = 0; r < ACTIVE; r++)
    begin : g_rule
        localparam int LEN = int'(nsm_pkg::SIG_LEN[r]);
        logic [MAX_PATTERN_LEN-1:0] eq;
        for (genvar k = 0; k < MAX_PATTERN_LEN; k++)
        begin : g_chr
            if (k < LEN)
            begin : g_on
                assign eq[k] = (q_req.ch == nsm_pkg::SIG_TEXT[r][8*(LEN-1-k) +: 8]);
            end
            else
            begin : g_off
                assign eq[k] = 1'b0;
            end
        end
        assign step_vec[r] = ((part_reg[r] << 1) | MAX_PATTERN_LEN'(1)) & eq;
        if (LEN <= MAX_PATTERN_LEN)
        begin : g_hit
            assign hit[r] = step_vec[r][LEN-1];
        end
        else
        begin : g_nohit
            assign hit[r] = 1'b0;
        end
    end

    assign q_pop     = q_valid && (!q_req.last || !oval_reg || out_ready);
    assign match_acc = (q_req.op == nsm_pkg::OP_SCAN) ? (match_reg | hit) : match_reg;

    // lowest matched rule wins
    always_comb
    begin
        blk = 1'b0;
        idx = '0;
        cat = nsm_pkg::CAT_SQLI;
        for (int r = ACTIVE - 1; r >= 0; r--)
        begin
            if (match_acc[r])
            begin
                blk = 1'b1;
                idx = 5'(r);
                cat = nsm_pkg::SIG_CAT[r];
            end
        end
    end

    always_comb
    begin
        part_next  = part_reg;
        match_next = match_reg;
        oval_next  = oval_reg && !out_ready;
        odat_next  = odat_reg;
        if (q_pop)
        begin
            case (q_req.op)
                nsm_pkg::OP_SCAN:
                begin
                    part_next  = step_vec;
                    match_next = match_acc;
                end
                nsm_pkg::OP_CLEAR:
                begin
                    for (int r = 0; r < ACTIVE; r++)
                    begin
                        part_next[r] = '0;
                    end
                end
                default:
                begin
                    part_next = part_reg;
                end
            endcase
            if (q_req.last)
            begin
                oval_next  = 1'b1;
                odat_next  = {cat, idx, blk};
                match_next = '0;
                for (int r = 0; r < ACTIVE; r++)
                begin
                    part_next[r] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ACTIVE; r++)
            begin
                part_reg[r] <= '0;
            end
            match_reg <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            part_reg  <= part_next;
            match_reg <= match_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odat_reg <= odat_next;
    end

    assign out_valid = oval_reg;
    assign out_data  = odat_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (oval_reg && !out_ready && q_valid && q_req.last) |-> !q_pop)
        else $error("result overwritten while stalled");

    a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_req.last) |=> (match_reg == '0))
        else $error("matched rules survive end of payload");

    a_index_matched: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_req.last) |=> (out_data[0] || (out_data[7:1] == '0)))
        else $error("unblocked result carries a rule");

endmodule

FILE: rtl/nocase_signature_matcher.sv
// m_axis_tvalid is registered: the last byte passes the two-entry request queue,
// then the output register. Throughput: one byte per cycle while the queue has room;
// the match engine updates all signature vectors for each byte in parallel.
// A stalled result holds in the output register while bytes keep arriving
// until the queue fills. rst_n is asynchronous, active low, and clears all
// partial matches, counters, the queue and the output valid.
module nocase_signature_matcher #(
    parameter int NUM_RULES       = 23,
    parameter int MAX_PATTERN_LEN = 18,
    parameter int MAX_TEXT_LEN    = 4095
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] blocked, [5:1] rule_index, [7:6] category
);

    nsm_pkg::req_t f_req, q_req;
    logic          f_valid, f_ready;
    logic          q_valid, q_pop;

    nsm_front #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .s_last     (s_axis_tlast),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_req   (f_req)
    );

    nsm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_req   (f_req),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_req    (q_req)
    );

    nsm_back #(
        .NUM_RULES       (NUM_RULES),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_req     (q_req),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

FILE: bench/tb_nocase_signature_matcher.sv
module tb_nocase_signature_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RULES     = 23;
    localparam int PAT_LEN     = 18;
    localparam int TEXT_CAP    = 4095;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_ITEMS  = 1300;

    // matches the m_axis_tdata layout, lowest bit last
    typedef struct packed {
        logic [1:0] category;
        logic [4:0] rule_index;
        logic       blocked;
    } verdict_t;

    class match_scoreboard;
        logic [PAT_LEN-1:0] partial [N_RULES];
        logic [N_RULES-1:0] hits;
        bit                 text_done;
        int unsigned        scan_len;
        verdict_t           verdict_q[$];
        int                 errors;
        int unsigned        scanned_items;

        function new();
            errors = 0;
            scanned_items = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (partial[r])
                partial[r] = '0;
            hits = '0;
            text_done = 1'b0;
            scan_len = 0;
        endfunction

        function string sig_of(int r);
            case (r)
                0:  return "union select";
                1:  return "union all select";
                2:  return "or 1=1";
                3:  return "' or '";
                4:  return "select * from";
                5:  return {"information", "_schema"};
                6:  return "<script>";
                7:  return "javascript:";
                8:  return "onerror=";
                9:  return "onload=";
                10: return "alert(";
                11: return "<svg/onload";
                12: return "../";
                13: return "..\\";
                14: return "/etc/passwd";
                15: return "/windows/win.ini";
                16: return "..\\..";
                17: return "; sh ";
                18: return "; bash ";
                19: return "| sh ";
                20: return "| bash ";
                21: return "&& id";
                default: return "&& whoami";
            endcase
        endfunction

        function logic [1:0] cat_of(int r);
            if (r < 6)
                return nsm_pkg::CAT_SQLI;
            else if (r < 12)
                return nsm_pkg::CAT_XSS;
            else if (r < 17)
                return nsm_pkg::CAT_PATH;
            return nsm_pkg::CAT_CMD;
        endfunction

        function void shift_in(logic [7:0] b);
            logic [7:0]         lc;
            logic [PAT_LEN-1:0] eq;
            logic [PAT_LEN-1:0] v;
            string              s;
            int                 len;
            lc = (b inside {[8'h41:8'h5A]}) ? b + 8'd32 : b;   // fold A..Z
            for (int r = 0; r < N_RULES; r++) begin
                s = sig_of(r);
                len = s.len();
                eq = '0;
                for (int k = 0; k < len && k < PAT_LEN; k++)
                    if (s[k] == lc)
                        eq[k] = 1'b1;
                v = ((partial[r] << 1) | PAT_LEN'(1)) & eq;
                partial[r] = v;
                if (len >= 1 && len <= PAT_LEN && v[len-1])
                    hits[r] = 1'b1;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            verdict_t want;
            if (!text_done && scan_len < TEXT_CAP) begin
                if (b == 8'h00) begin
                    text_done = 1'b1;
                    foreach (partial[r])
                        partial[r] = '0;
                end
                else begin
                    shift_in(b);
                    scan_len++;
                    scanned_items++;
                end
            end
            if (last) begin
                want = '0;
                for (int r = 0; r < N_RULES; r++)
                    if (hits[r]) begin
                        want.blocked = 1'b1;
                        want.rule_index = 5'(r);
                        want.category = cat_of(r);
                        break;
                    end
                verdict_q.push_back(want);
                clear_text();
            end
        endfunction

        function void check_verdict(logic [7:0] word);
            verdict_t got;
            verdict_t want;
            got = word;
            if (verdict_q.size() == 0) begin
                $display("%0t: result with none outstanding, actual %h", $time, word);
                errors++;
                return;
            end
            want = verdict_q.pop_front();
            if (got.blocked !== want.blocked) begin
                $display("%0t: blocked expected %0d actual %0d", $time,
                         want.blocked, got.blocked);
                errors++;
            end
            if (got.rule_index !== want.rule_index) begin
                $display("%0t: rule_index expected %0d actual %0d", $time,
                         want.rule_index, got.rule_index);
                errors++;
            end
            if (got.category !== want.category) begin
                $display("%0t: category expected %0d actual %0d", $time,
                         want.category, got.category);
                errors++;
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;

    match_scoreboard sb;
    logic [7:0]      payload[$];
    int              burst_left;
    int              cycles;
    int              rx_mode;
    int              rx_left;

    nocase_signature_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check, then pick the stall pattern for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_verdict(m_axis_tdata);
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(3, 0);
            rx_left = $urandom_range(80, 5);
        end
        else
            rx_left = rx_left - 1;
        case (rx_mode)
            0, 1:    m_axis_tready <= 1'b1;
            2:       m_axis_tready <= ($urandom_range(1, 0) == 1);
            default: m_axis_tready <= ($urandom_range(7, 0) == 0);
        endcase
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                      : $urandom_range(30, 1);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_byte(b, last);
        burst_left--;
    endtask

    task automatic send_payload();
        for (int i = 0; i < payload.size(); i++)
            push_byte(payload[i], i == payload.size() - 1);
        payload.delete();
    endtask

    // hold the request side until every outstanding result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic void add_text(string s, bit mix_case);
        logic [7:0] c;
        for (int k = 0; k < s.len(); k++)
        begin
            c = s[k];
            if (mix_case && (c inside {[8'h61:8'h7A]}) && $urandom_range(1, 0) == 1)
                c = c - 8'd32;
            payload.push_back(c);
        end
    endfunction

    function automatic void add_sig(int r, bit cut);
        string s;
        s = sb.sig_of(r);
        if (cut)
            s = s.substr(0, $urandom_range(s.len() - 2, 0));
        add_text(s, 1'b1);
    endfunction

    function automatic void add_noise(int n);
        string pool;
        int    p;
        pool = "abcxyz ./\\;|&<>'=*:(1_-onlsehiwtprjav";
        for (int i = 0; i < n; i++)
            if ($urandom_range(4, 0) == 0)
                payload.push_back(8'($urandom_range(255, 1)));
            else
            begin
                p = $urandom_range(pool.len() - 1, 0);
                add_text(pool.substr(p, p), 1'b1);
            end
    endfunction

    function automatic void build_random_payload();
        int segs;
        int pick;
        if ($urandom_range(29, 0) == 0)
        begin
            // raw bytes, zeros allowed anywhere
            repeat ($urandom_range(20, 1))
                payload.push_back(8'($urandom_range(255, 0)));
            return;
        end
        segs = $urandom_range(5, 1);
        for (int i = 0; i < segs; i++)
        begin
            pick = $urandom_range(9, 0);
            if (pick < 4)
                add_sig($urandom_range(N_RULES - 1, 0), 1'b0);
            else if (pick < 6)
                add_sig($urandom_range(N_RULES - 1, 0), 1'b1);
            else
                add_noise($urandom_range(8, 1));
            if ($urandom_range(24, 0) == 0)
                payload.push_back(8'h00);
        end
    endfunction

    initial
    begin
        int n_texts;
        sb = new();
        cycles = 0;
        rx_mode = 0;
        rx_left = 0;
        burst_left = 0;
        rst_n = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty text, then a lone 0xff
        payload.push_back(8'h00);
        send_payload();
        payload.push_back(8'hFF);
        send_payload();
        // upper case must still match
        add_text("<SCRIPT>", 1'b0);
        send_payload();
        // signature after the terminating zero is not scanned
        payload.push_back(8'h00);
        add_text("../", 1'b0);
        send_payload();
        // two rules overlap, lower index wins
        add_text("..\\..", 1'b0);
        send_payload();
        drain_results();

        n_texts = 0;
        while (sb.scanned_items < RAND_ITEMS)
        begin
            build_random_payload();
            send_payload();
            n_texts++;
            if (n_texts % 20 == 0)
                drain_results();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/nsm_pkg.sv
rtl/nsm_front.sv
rtl/nsm_fifo.sv
rtl/nsm_back.sv
rtl/nocase_signature_matcher.sv
bench/tb_nocase_signature_matcher.sv
